>>> src/lj_pairwise_force_accumulator_core_assert.svh
// Assertion macros used by the checker file of the force accumulator core.
`ifndef LJ_PAIRWISE_FORCE_ACCUMULATOR_CORE_ASSERT_SVH
`define LJ_PAIRWISE_FORCE_ACCUMULATOR_CORE_ASSERT_SVH

// Condition in this cycle implies a condition in the same cycle.
`define LJ_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Condition in this cycle implies a condition in the next cycle.
`define LJ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/ljfa_pkg.sv
// Shared types and constants of the Lennard-Jones force accumulator.
package ljfa_pkg;

  localparam int POS_W    = 24;  // unsigned Q8.16 coordinate
  localparam int FRC_W    = 32;  // signed Q16.16 force
  localparam int PIDX_W   = 6;   // particle index field
  localparam int CFG_W    = 2;   // register index
  localparam int MAG_W    = 25;  // minimum-image distance magnitude
  localparam int SQ_W     = 50;  // one squared axis distance
  localparam int R_W      = 52;  // squared distance, Q.32
  localparam int DIV_W    = 40;  // divisor / remainder in the divider chain
  localparam int QUO_W    = 28;  // 1/r^2 in Q.24
  localparam int FLIGHT_W = 6;   // pairs in flight

  localparam logic [POS_W-1:0] BOX_RST = 24'd655360;
  localparam logic [POS_W-1:0] CUT_RST = 24'd409600;

  typedef enum logic [CFG_W-1:0] {
    REG_BOX_X  = 2'd0,
    REG_BOX_Y  = 2'd1,
    REG_BOX_Z  = 2'd2,
    REG_CUTOFF = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIDX_W-1:0]           j;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0]                  neg;
    logic                        interact;
    logic                        close;
  } pair_tag_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
    pair_tag_t        tag;
  } div_data_t;

  typedef struct packed {
    logic              valid;
    logic [PIDX_W-1:0] j;
  } pipe_peek_t;

  typedef struct packed {
    logic                  valid;
    logic [PIDX_W-1:0]     j;
    logic [2:0][FRC_W-1:0] f;
  } pipe_out_t;

endpackage

>>> src/ljfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ljfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ljfa_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands on.
module ljfa_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ljfa_pkg::div_data_t in_data,
  output logic                out_valid,
  output ljfa_pkg::div_data_t out_data
);
  import ljfa_pkg::*;

  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] trial;
  logic             ge;

  assign shifted = {in_data.rem, 1'b0};
  assign trial   = {1'b0, shifted} - {2'b00, in_data.dvs};
  assign ge      = !trial[DIV_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data.rem <= ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    out_data.dvs <= in_data.dvs;
    out_data.quo <= {in_data.quo[QUO_W-2:0], ge};
    out_data.tag <= in_data.tag;
  end

endmodule

>>> src/ljfa_pair_pipe.sv
// Pair force pipeline: minimum image, r^2, divider chain, LJ scale, force.
module ljfa_pair_pipe #(
  parameter int DIMENSIONS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic [ljfa_pkg::PIDX_W-1:0]          in_j,
  input  logic [2:0][ljfa_pkg::POS_W-1:0]      pos_i,
  input  logic [2:0][ljfa_pkg::POS_W-1:0]      pos_j,
  input  logic [2:0][ljfa_pkg::POS_W-1:0]      box_len,
  input  logic [ljfa_pkg::POS_W-1:0]           cutoff_sq,
  output ljfa_pkg::pipe_peek_t                 peek,
  output ljfa_pkg::pipe_out_t                  result
);
  import ljfa_pkg::*;

  // stage A: minimum image
  logic signed [25:0] diff_a [3];
  logic [25:0]        dabs_a [3];
  logic signed [25:0] wrap_a [3];
  logic [25:0]        wabs_a [3];
  pair_tag_t          tag_a_next;
  logic               va;
  pair_tag_t          tag_a;

  always_comb begin
    tag_a_next   = '0;
    tag_a_next.j = in_j;
    for (int a = 0; a < 3; a++) begin
      diff_a[a] = $signed({2'b00, pos_i[a]}) - $signed({2'b00, pos_j[a]});
      dabs_a[a] = diff_a[a][25] ? 26'(-diff_a[a]) : 26'(diff_a[a]);
      if ({dabs_a[a], 1'b0} > {3'b000, box_len[a]}) begin
        if (diff_a[a] > 0) begin
          wrap_a[a] = diff_a[a] - $signed({2'b00, box_len[a]});
        end else begin
          wrap_a[a] = diff_a[a] + $signed({2'b00, box_len[a]});
        end
      end else begin
        wrap_a[a] = diff_a[a];
      end
      if (a >= DIMENSIONS) begin
        wrap_a[a] = '0;
      end
      wabs_a[a] = wrap_a[a][25] ? 26'(-wrap_a[a]) : 26'(wrap_a[a]);
      tag_a_next.neg[a] = wrap_a[a][25];
      tag_a_next.mag[a] = wabs_a[a][MAG_W-1:0];
    end
  end

  // stage B: squares
  logic                 vb;
  pair_tag_t            tag_b;
  logic [2:0][SQ_W-1:0] sq_b;

  // stage C: r^2, cutoff test, divider setup
  logic [R_W-1:0] r_sum;
  div_data_t      data_c_next;
  logic           vc;
  div_data_t      data_c;

  always_comb begin
    r_sum = R_W'(sq_b[0]) + R_W'(sq_b[1]) + R_W'(sq_b[2]);
    data_c_next              = '0;
    data_c_next.tag          = tag_b;
    data_c_next.tag.interact = (r_sum != '0) && (r_sum < {12'd0, cutoff_sq, 16'd0});
    data_c_next.tag.close    = r_sum <= R_W'(64'h1000_0000);
    data_c_next.rem          = DIV_W'(64'h1000_0000);
    data_c_next.dvs          = r_sum[DIV_W-1:0];
    data_c_next.quo          = '0;
  end

  // divider chain: x = 2^56 / r^2, one quotient bit per cell
  logic      cv [QUO_W+1];
  div_data_t cd [QUO_W+1];

  assign cv[0] = vc;
  assign cd[0] = data_c;

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    ljfa_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cv[g]),
      .in_data  (cd[g]),
      .out_valid(cv[g+1]),
      .out_data (cd[g+1])
    );
  end

  // scale stages
  logic        v1, v2, v3, v4, v5;
  pair_tag_t   tag1, tag2, tag3, tag4, tag5;
  logic [QUO_W-1:0] x1;
  logic [31:0] x2_1;
  logic [55:0] p_xx;
  logic [59:0] p_x3;
  logic [63:0] p_x4;
  logic [35:0] x3_2;
  logic [39:0] x4_2;
  logic [36:0] t_3;
  logic [36:0] tm_3;
  logic        sneg_3, sneg_4, sneg_5;
  logic [44:0] a24_3;
  logic [63:0] plo_4;
  logic [62:0] phi_4;
  logic [81:0] full_5;
  logic [53:0] sh_5;
  logic [51:0] s_next;
  logic        sneg_next;
  logic [51:0] s_5;

  assign p_xx = cd[QUO_W].quo * cd[QUO_W].quo;
  assign p_x3 = x2_1 * x1;
  assign p_x4 = x2_1 * x2_1;
  assign t_3  = {x3_2, 1'b0};
  assign full_5 = {phi_4, 19'd0} + 82'(plo_4);
  assign sh_5   = full_5[81:28];

  always_comb begin
    s_next    = (sh_5 >= 54'h8_0000_0000_0000) ? 52'h8_0000_0000_0000 : sh_5[51:0];
    sneg_next = sneg_4;
    if (!tag4.interact) begin
      s_next    = '0;
      sneg_next = 1'b0;
    end else if (tag4.close) begin
      s_next    = 52'h8_0000_0000_0000;
      sneg_next = 1'b0;
    end
  end

  // force stages
  logic                v6, v7;
  pair_tag_t           tag6;
  logic                sneg_6;
  logic [2:0][50:0]    plo_6;
  logic [2:0][50:0]    phi_6;
  logic [76:0]         full_7 [3];
  logic [56:0]         sh_7 [3];
  logic [31:0]         fm_7 [3];
  logic [2:0][FRC_W-1:0] f_next;
  logic [PIDX_W-1:0]   j7;
  logic [2:0][FRC_W-1:0] f7;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      full_7[a] = {phi_6[a], 26'd0} + 77'(plo_6[a]);
      sh_7[a]   = full_7[a][76:20];
      fm_7[a]   = (sh_7[a] >= 57'h8000_0000) ? 32'h8000_0000 : sh_7[a][31:0];
      if (tag6.neg[a] ^ sneg_6) begin
        f_next[a] = 32'd0 - fm_7[a];
      end else begin
        f_next[a] = fm_7[a][31] ? 32'h7FFF_FFFF : fm_7[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      v1 <= cv[QUO_W];
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    tag_a  <= tag_a_next;
    tag_b  <= tag_a;
    for (int a = 0; a < 3; a++) begin
      sq_b[a] <= tag_a.mag[a] * tag_a.mag[a];
    end
    data_c <= data_c_next;
    // 1/r^2 powers
    tag1   <= cd[QUO_W].tag;
    x1     <= cd[QUO_W].quo;
    x2_1   <= p_xx[55:24];
    tag2   <= tag1;
    x3_2   <= p_x3[59:24];
    x4_2   <= p_x4[63:24];
    // 2/r^6 - 1 and 24/r^8
    tag3   <= tag2;
    if (t_3 >= 37'h100_0000) begin
      tm_3   <= t_3 - 37'h100_0000;
      sneg_3 <= 1'b0;
    end else begin
      tm_3   <= 37'h100_0000 - t_3;
      sneg_3 <= 1'b1;
    end
    a24_3  <= 45'({x4_2, 4'd0}) + 45'({x4_2, 3'd0});
    // scale product in two partial products
    tag4   <= tag3;
    sneg_4 <= sneg_3;
    plo_4  <= a24_3 * tm_3[18:0];
    phi_4  <= a24_3 * tm_3[36:19];
    tag5   <= tag4;
    s_5    <= s_next;
    sneg_5 <= sneg_next;
    // per-axis force, split over the scale halves
    tag6   <= tag5;
    sneg_6 <= sneg_5;
    for (int a = 0; a < 3; a++) begin
      plo_6[a] <= tag5.mag[a] * s_5[25:0];
      phi_6[a] <= tag5.mag[a] * s_5[51:26];
    end
    j7 <= tag6.j;
    f7 <= f_next;
  end

  assign peek.valid   = v6;
  assign peek.j       = tag6.j;
  assign result.valid = v7;
  assign result.j     = j7;
  assign result.f     = f7;

endmodule

>>> src/lj_pairwise_force_accumulator_core.sv
// Top level of the Lennard-Jones pairwise force accumulator.
//
// Usage:
//   Config: cfg_valid/cfg_ready (ready is always high) writes cfg_data to
//   the register picked by cfg_index: box x, box y, box z, squared cutoff.
//   Write only while the block waits for positions.
//   Input: one particle position per item on pos_valid/pos_stall, one per
//   cycle while pos_stall is low. last_particle ends the set and starts the
//   compute; pos_stall stays high until the last force of the run is taken.
//   Output: one total force per particle on force_valid/force_stall, in
//   load order, last_force on the final one. A stalled result holds.
//   Timing: row i issues n-1-i pairs one per cycle into a 38-stage pair
//   pipeline (28 of them a chain of divider cells), then drains it before
//   the row's own sum is written back. Results then go out one at a time,
//   each read from the accumulator RAM and held until it is taken.
//   Reset: registers return to their defaults, the particle count to zero.
//   Accumulators need no clearing pass: the first row overwrites every
//   entry of the current set.
module lj_pairwise_force_accumulator_core #(
  parameter int MAX_PARTICLES = 64,
  parameter int DIMENSIONS    = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ljfa_pkg::CFG_W-1:0]        cfg_index,
  input  logic [ljfa_pkg::POS_W-1:0]        cfg_data,
  input  logic                              pos_valid,
  output logic                              pos_stall,
  input  logic [ljfa_pkg::POS_W-1:0]        pos_x,
  input  logic [ljfa_pkg::POS_W-1:0]        pos_y,
  input  logic [ljfa_pkg::POS_W-1:0]        pos_z,
  input  logic                              last_particle,
  output logic                              force_valid,
  input  logic                              force_stall,
  output logic [ljfa_pkg::PIDX_W-1:0]       particle_index,
  output logic signed [ljfa_pkg::FRC_W-1:0] force_x,
  output logic signed [ljfa_pkg::FRC_W-1:0] force_y,
  output logic signed [ljfa_pkg::FRC_W-1:0] force_z,
  output logic                              last_force
);
  import ljfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PARTICLES);

  typedef enum logic [3:0] {
    S_LOAD,
    S_ROW_RD,
    S_ROW_LATCH,
    S_ISSUE,
    S_DRAIN,
    S_ROW_WB,
    S_OUT_RD,
    S_OUT_CAP,
    S_OUT_SEND
  } state_t;

  function automatic logic [FRC_W-1:0] sat32(input logic signed [FRC_W+1:0] v);
    if (v > 34'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[FRC_W-1:0];
    end
  endfunction

  // configuration registers
  logic [2:0][POS_W-1:0] box_len;
  logic [POS_W-1:0]      cutoff_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_len   <= {BOX_RST, BOX_RST, BOX_RST};
      cutoff_sq <= CUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BOX_X:  box_len[0] <= cfg_data;
        REG_BOX_Y:  box_len[1] <= cfg_data;
        REG_BOX_Z:  box_len[2] <= cfg_data;
        REG_CUTOFF: cutoff_sq  <= cfg_data;
        default:    cutoff_sq  <= cutoff_sq;
      endcase
    end
  end

  state_t                state;
  logic [CNT_W-1:0]      cnt;      // particles stored in this set
  logic [CNT_W-1:0]      n;
  logic [CNT_W-1:0]      i;        // current row
  logic [CNT_W-1:0]      j;        // next partner to issue
  logic [CNT_W-1:0]      k;        // result being sent
  logic [2:0][POS_W-1:0] pi;
  logic [2:0][FRC_W-1:0] rs;       // running sum of row particle
  logic                  s0_valid;
  logic [PIDX_W-1:0]     s0_j;
  logic [FLIGHT_W-1:0]   flight;

  // memories
  logic                  coord_we;
  logic [IDX_W-1:0]      coord_raddr;
  logic [2:0][POS_W-1:0] coord_rd;
  logic                  acc_we;
  logic [IDX_W-1:0]      acc_waddr;
  logic [2:0][FRC_W-1:0] acc_wdata;
  logic [IDX_W-1:0]      acc_raddr;
  logic [2:0][FRC_W-1:0] acc_rd;

  pipe_peek_t            peek;
  pipe_out_t             result;
  logic                  issue;
  logic                  first_row;
  logic [2:0][FRC_W-1:0] acc_old;
  logic [2:0][FRC_W-1:0] acc_new;
  logic [2:0][FRC_W-1:0] rs_next;

  assign pos_stall = (state != S_LOAD);
  assign issue     = (state == S_ISSUE) && (j < n);
  assign first_row = (i == '0);
  assign coord_we  = pos_valid && !pos_stall && (cnt < MAX_CNT);

  always_comb begin
    coord_raddr = (state == S_ISSUE) ? j[IDX_W-1:0] : i[IDX_W-1:0];
    priority if (state == S_ROW_RD) begin
      acc_raddr = i[IDX_W-1:0];
    end else if (state == S_OUT_RD) begin
      acc_raddr = k[IDX_W-1:0];
    end else begin
      acc_raddr = peek.j[IDX_W-1:0];
    end
  end

  // pair result: subtract from partner, add to the row sum
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_old[a] = first_row ? '0 : acc_rd[a];
      acc_new[a] = sat32({{2{acc_old[a][FRC_W-1]}}, acc_old[a]}
                       - {{2{result.f[a][FRC_W-1]}}, result.f[a]});
      rs_next[a] = sat32({{2{rs[a][FRC_W-1]}}, rs[a]}
                       + {{2{result.f[a][FRC_W-1]}}, result.f[a]});
    end
  end

  assign acc_we    = (state == S_ROW_WB) || result.valid;
  assign acc_waddr = (state == S_ROW_WB) ? i[IDX_W-1:0] : result.j[IDX_W-1:0];
  assign acc_wdata = (state == S_ROW_WB) ? rs : acc_new;

  ljfa_ram #(.WIDTH(3 * POS_W), .DEPTH(MAX_PARTICLES)) u_coord_ram (
    .clk  (clk),
    .we   (coord_we),
    .waddr(cnt[IDX_W-1:0]),
    .wdata({pos_z, pos_y, pos_x}),
    .raddr(coord_raddr),
    .rdata(coord_rd)
  );

  ljfa_ram #(.WIDTH(3 * FRC_W), .DEPTH(MAX_PARTICLES)) u_acc_ram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(acc_waddr),
    .wdata(acc_wdata),
    .raddr(acc_raddr),
    .rdata(acc_rd)
  );

  ljfa_pair_pipe #(.DIMENSIONS(DIMENSIONS)) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s0_valid),
    .in_j     (s0_j),
    .pos_i    (pi),
    .pos_j    (coord_rd),
    .box_len  (box_len),
    .cutoff_sq(cutoff_sq),
    .peek     (peek),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      cnt         <= '0;
      s0_valid    <= 1'b0;
      flight      <= '0;
      force_valid <= 1'b0;
    end else begin
      s0_valid <= 1'b0;
      flight   <= flight + FLIGHT_W'(issue) - FLIGHT_W'(result.valid);
      if (result.valid) begin
        rs <= rs_next;
      end
      unique case (state)
        S_LOAD: begin
          if (pos_valid) begin
            if (cnt < MAX_CNT) begin
              cnt <= cnt + CNT_W'(1);
            end
            if (last_particle) begin
              n     <= (cnt < MAX_CNT) ? cnt + CNT_W'(1) : cnt;
              i     <= '0;
              state <= S_ROW_RD;
            end
          end
        end
        S_ROW_RD: begin
          state <= S_ROW_LATCH;
        end
        S_ROW_LATCH: begin
          pi    <= coord_rd;
          rs    <= first_row ? '0 : acc_rd;
          j     <= i + CNT_W'(1);
          state <= S_ISSUE;
        end
        S_ISSUE: begin
          if (j < n) begin
            s0_valid <= 1'b1;
            s0_j     <= PIDX_W'(j);
            j        <= j + CNT_W'(1);
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (flight == '0) begin
            state <= S_ROW_WB;
          end
        end
        S_ROW_WB: begin
          i <= i + CNT_W'(1);
          if (((CNT_W+1)'(i) + (CNT_W+1)'(2)) < (CNT_W+1)'(n)) begin
            state <= S_ROW_RD;
          end else begin
            k     <= '0;
            state <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_CAP;
        end
        S_OUT_CAP: begin
          force_valid    <= 1'b1;
          particle_index <= PIDX_W'(k);
          force_x        <= $signed(acc_rd[0]);
          force_y        <= $signed(acc_rd[1]);
          force_z        <= $signed(acc_rd[2]);
          last_force     <= ((k + CNT_W'(1)) == n);
          state          <= S_OUT_SEND;
        end
        S_OUT_SEND: begin
          if (!force_stall) begin
            force_valid <= 1'b0;
            k           <= k + CNT_W'(1);
            if (last_force) begin
              cnt   <= '0;
              state <= S_LOAD;
            end else begin
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

>>> src/ljfa_chk.sv
// Port-level checker for the force accumulator core, bound to the top level.
`include "lj_pairwise_force_accumulator_core_assert.svh"

module ljfa_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              pos_valid,
  input logic                              pos_stall,
  input logic                              last_particle,
  input logic                              force_valid,
  input logic                              force_stall,
  input logic [ljfa_pkg::PIDX_W-1:0]       particle_index,
  input logic signed [ljfa_pkg::FRC_W-1:0] force_x,
  input logic                              last_force
);

  `LJ_ASSERT_NOW(a_no_load_while_sending, force_valid, pos_stall, "position taken during output")
  `LJ_ASSERT_NEXT(a_last_starts_compute, pos_valid && !pos_stall && last_particle, pos_stall, "no compute after last particle")
  `LJ_ASSERT_NEXT(a_last_ends_run, force_valid && !force_stall && last_force, !force_valid, "result after last force")
  `LJ_ASSERT_NEXT(a_held_result, force_valid && force_stall, force_valid && $stable(force_x) && $stable(particle_index), "stalled result changed")

endmodule

bind lj_pairwise_force_accumulator_core ljfa_chk u_ljfa_chk (
  .clk           (clk),
  .rst           (rst),
  .pos_valid     (pos_valid),
  .pos_stall     (pos_stall),
  .last_particle (last_particle),
  .force_valid   (force_valid),
  .force_stall   (force_stall),
  .particle_index(particle_index),
  .force_x       (force_x),
  .last_force    (last_force)
);
